// File: sv/tcd_pkg.sv
// ----------------------------------------------------------------------------
// Tag command detector package
// Character codes, keyword and attribute tables, and the state encodings
// shared by the tag command detector.
// ----------------------------------------------------------------------------
package tcd_pkg;

	localparam int KwCount = 5;
	localparam int KwMaxLen = 6;
	localparam int AttrLen = 7;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	// Keywords, padded with NUL to the longest one. Row order is event order.
	localparam logic [7:0] KW_TEXT [KwCount][KwMaxLen] = '{
		'{"p", "h", "o", "t", "o", 8'h00},
		'{"s", "t", "o", "r", "y", 8'h00},
		'{"s", "o", "u", "n", "d", 8'h00},
		'{"s", "t", "r", "e", "a", "m"},
		'{"g", "a", "m", "e", 8'h00, 8'h00}
	};
	localparam logic [2:0] KW_LEN [KwCount] = '{3'd5, 3'd5, 3'd5, 3'd6, 3'd4};

	localparam logic [7:0] ATTR_TEXT [AttrLen] = '{"s", "t", "a", "t", "e", "=", 8'h22};
	localparam logic [2:0] ATTR_DONE = 3'(AttrLen);

	typedef enum logic [2:0] {
		CMD_PHOTO  = 3'd0,
		CMD_STORY  = 3'd1,
		CMD_SOUND  = 3'd2,
		CMD_STREAM = 3'd3,
		CMD_GAME   = 3'd4
	} cmd_t;

	typedef enum logic [2:0] {
		PH_WAIT_FEATURE = 3'd0,
		PH_FEATURE_NAME = 3'd1,
		PH_WAIT_TAG     = 3'd2,
		PH_IN_TAG       = 3'd3,
		PH_WAIT_CLOSE   = 3'd4,
		PH_TAG_ENDED    = 3'd5
	} phase_t;

	typedef enum logic [1:0] {
		NUM_ATTR   = 2'd0,
		NUM_SIGN   = 2'd1,
		NUM_DIGITS = 2'd2,
		NUM_DONE   = 2'd3
	} num_phase_t;

endpackage

// File: sv/tag_command_detector_core.sv
// ----------------------------------------------------------------------------
// Tag command detector core
// Parses feature framing in a byte stream and raises command events.
// ----------------------------------------------------------------------------
// Usage: the slave side takes one character of command text per request in
// s_tdata. The block tracks <feature><cmd .../>...</feature> framing; inside
// each inner tag it looks for the keywords photo, story, sound, stream and
// game and for the attribute state=" followed by a decimal value. When a tag
// closes with '>' and the value holds a nonzero digit, the first keyword
// present in row order gives one master request with the event code.
// Most characters give no result at all.
// Latency: an event appears on m_tvalid in the cycle after the closing '>'
// is accepted. Throughput: one character per cycle; all parsing is a single
// level of small matchers between the state registers and the result
// register, so nothing limits the rate but the output handshake.
// Reset clears the framing state to "waiting for feature open" and drops
// any pending event. When the receiver stalls with an event waiting, the
// slave side is held off until that event is taken; while the result
// register is empty or being emptied, a new character is taken every cycle.
// ----------------------------------------------------------------------------
module tag_command_detector_core
	import tcd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] in_byte
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata    // [2:0] command, [7:3] zero
);

	// Parser state.
	phase_t     phase_q, phase_d;
	logic [7:0] held_char_q, held_char_d;
	logic       held_valid_q, held_valid_d;
	logic [2:0] kw_prog_q [KwCount];
	logic [2:0] kw_prog_d [KwCount];
	logic [KwCount-1:0] kw_seen_q, kw_seen_d;
	logic [2:0] attr_prog_q, attr_prog_d;
	num_phase_t num_q, num_d;
	logic       nonzero_q, nonzero_d;

	// Result register.
	logic       m_tvalid_q;
	cmd_t       cmd_q, cmd_d;
	logic       emit;

	// Committed-character helpers.
	logic       accept;
	logic       do_commit;
	logic       do_clear;
	logic [7:0] cc;
	logic       cc_space;
	logic       cc_digit;
	logic [2:0] kp [KwCount];
	logic [2:0] ap;

	assign accept   = s_tvalid && s_tready;
	assign s_tready = !m_tvalid_q || m_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {5'd0, cmd_q};

	// The held character is the one that enters the tag text; the character
	// just received is held back so that the last one before '>' is left out.
	assign cc       = held_char_q;
	assign cc_space = (cc == CH_SPACE) || (cc >= CH_TAB && cc <= CH_CR);
	assign cc_digit = (cc >= CH_ZERO) && (cc <= CH_NINE);

	always_comb begin
		phase_d      = phase_q;
		held_char_d  = held_char_q;
		held_valid_d = held_valid_q;
		kw_seen_d    = kw_seen_q;
		attr_prog_d  = attr_prog_q;
		num_d        = num_q;
		nonzero_d    = nonzero_q;
		for (int k = 0; k < KwCount; k++) begin
			kw_prog_d[k] = kw_prog_q[k];
			kp[k]        = 3'd0;
		end
		ap        = 3'd0;
		emit      = 1'b0;
		cmd_d     = cmd_q;
		do_commit = 1'b0;
		do_clear  = 1'b0;

		unique case (phase_q)
			PH_FEATURE_NAME: begin
				if (s_tdata == CH_GT)
					phase_d = PH_WAIT_TAG;
			end
			PH_WAIT_TAG: begin
				if (s_tdata == CH_LT) begin
					phase_d  = PH_IN_TAG;
					do_clear = 1'b1;
				end
			end
			PH_IN_TAG, PH_TAG_ENDED: begin
				if (s_tdata == CH_SLASH && !held_valid_q) begin
					phase_d = PH_WAIT_CLOSE;
				end else if (s_tdata == CH_GT) begin
					if (num_q != NUM_ATTR && nonzero_q) begin
						emit = |kw_seen_q;
						for (int k = KwCount - 1; k >= 0; k--) begin
							if (kw_seen_q[k])
								cmd_d = cmd_t'(3'(k));
						end
					end
					phase_d = PH_WAIT_TAG;
				end else begin
					do_commit    = held_valid_q && (phase_q == PH_IN_TAG);
					held_char_d  = s_tdata;
					held_valid_d = 1'b1;
				end
			end
			PH_WAIT_CLOSE: begin
				if (s_tdata == CH_GT)
					phase_d = PH_WAIT_FEATURE;
			end
			default: begin
				phase_d = (s_tdata == CH_LT) ? PH_FEATURE_NAME : PH_WAIT_FEATURE;
			end
		endcase

		if (do_commit) begin
			if (cc == CH_NUL) begin
				// A NUL ends the tag text; the tag still runs to '>'.
				phase_d = PH_TAG_ENDED;
			end else begin
				// Each pattern's first letter occurs once in it, so a mismatch
				// can only restart on that first letter.
				for (int k = 0; k < KwCount; k++) begin
					kp[k] = (kw_prog_q[k] >= KW_LEN[k]) ? 3'd0 : kw_prog_q[k];
					if (KW_TEXT[k][kp[k]] == cc)
						kp[k] = kp[k] + 3'd1;
					else
						kp[k] = (KW_TEXT[k][0] == cc) ? 3'd1 : 3'd0;
					if (kp[k] == KW_LEN[k])
						kw_seen_d[k] = 1'b1;
					kw_prog_d[k] = kp[k];
				end
				unique case (num_q)
					NUM_ATTR: begin
						ap = (attr_prog_q == ATTR_DONE) ? 3'd0 : attr_prog_q;
						if (ATTR_TEXT[ap] == cc)
							ap = ap + 3'd1;
						else
							ap = (ATTR_TEXT[0] == cc) ? 3'd1 : 3'd0;
						if (ap == ATTR_DONE) begin
							attr_prog_d = 3'd0;
							num_d       = NUM_SIGN;
						end else begin
							attr_prog_d = ap;
						end
					end
					NUM_SIGN: begin
						if (cc_space) begin
							num_d = NUM_SIGN;
						end else if (cc == CH_PLUS || cc == CH_MINUS) begin
							num_d = NUM_DIGITS;
						end else if (cc_digit) begin
							num_d = NUM_DIGITS;
							if (cc != CH_ZERO)
								nonzero_d = 1'b1;
						end else begin
							num_d = NUM_DONE;
						end
					end
					NUM_DIGITS: begin
						if (cc_digit) begin
							if (cc != CH_ZERO)
								nonzero_d = 1'b1;
						end else begin
							num_d = NUM_DONE;
						end
					end
					default: begin
						num_d = NUM_DONE;
					end
				endcase
			end
		end

		if (do_clear) begin
			held_char_d  = 8'd0;
			held_valid_d = 1'b0;
			for (int k = 0; k < KwCount; k++)
				kw_prog_d[k] = 3'd0;
			kw_seen_d   = '0;
			attr_prog_d = 3'd0;
			num_d       = NUM_ATTR;
			nonzero_d   = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_WAIT_FEATURE;
			held_char_q  <= 8'd0;
			held_valid_q <= 1'b0;
			for (int k = 0; k < KwCount; k++)
				kw_prog_q[k] <= 3'd0;
			kw_seen_q    <= '0;
			attr_prog_q  <= 3'd0;
			num_q        <= NUM_ATTR;
			nonzero_q    <= 1'b0;
		end else if (accept) begin
			phase_q      <= phase_d;
			held_char_q  <= held_char_d;
			held_valid_q <= held_valid_d;
			for (int k = 0; k < KwCount; k++)
				kw_prog_q[k] <= kw_prog_d[k];
			kw_seen_q    <= kw_seen_d;
			attr_prog_q  <= attr_prog_d;
			num_q        <= num_d;
			nonzero_q    <= nonzero_d;
		end
	end

	// Result register: loaded on an accepted character that raises an event,
	// emptied when the receiver takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (accept) begin
			m_tvalid_q <= emit;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && emit)
			cmd_q <= cmd_d;
	end

`ifndef SYNTHESIS
	a_ended_has_held: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_TAG_ENDED |-> held_valid_q)
		else $error("tag text ended without a held character");

	a_no_value_before_attr: assert property (@(posedge clk) disable iff (!arst_n)
		num_q == NUM_ATTR |-> !nonzero_q)
		else $error("value flagged nonzero before the attribute was found");

	a_event_from_tag: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(phase_q == PH_IN_TAG || phase_q == PH_TAG_ENDED))
		else $error("event raised outside a tag");

	a_event_code_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[2:0] <= CMD_GAME)
		else $error("event code out of range");
`endif

endmodule
